// File: design/tdp_pc_pkg.sv
// Shared constants and types for the TDP preamble correlator.
package tdp_pc_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int PATTERN_CHIPS = 60;
    localparam int BASE_CHIPS    = 15;
    localparam int HIST_DEPTH    = 2 * PATTERN_CHIPS - 1;
    localparam int SUM_W         = 22;
    localparam int THR_W         = 22;
    localparam int TOPO_W        = 2;
    localparam int NUM_TOPO      = 4;
    localparam int ADDR_W        = 4;
    localparam int DATA_W        = 32;
    localparam int REG_IDX_W     = 2;

    localparam logic signed [THR_W-1:0] THR_RESET = 22'sd40;

    localparam logic [REG_IDX_W-1:0] REG_TOPOLOGY  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_VPPM      = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

    // One row per topology; bit k is set where base chip k is -1.
    localparam logic [NUM_TOPO-1:0][BASE_CHIPS-1:0] BASE_NEG = {
        15'b010110100111101,
        15'b001101111100110,
        15'b100000010001011,
        15'b111011001010000
    };

    typedef struct packed {
        logic                     valid;
        logic signed [SUM_W-1:0]  sum;
    } psum_t;

    typedef struct packed {
        logic vppm;
        logic neg;
    } cell_ctl_t;

endpackage

// File: design/tdp_pc_if.sv
// Valid/ready channel interfaces for samples in and detection flags out.
interface tdp_pc_sample_if;
    import tdp_pc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface tdp_pc_detect_if;
    logic valid;
    logic ready;
    logic detected;

    modport source (output valid, output detected, input ready);
    modport sink (input valid, input detected, output ready);
endinterface

// File: design/tdp_preamble_correlator_top.sv
// Top level of the TDP preamble correlator: history line, cell chain, APB registers.
//
// Usage: signed samples arrive as beats on the samples channel (valid/ready);
// one detection flag per sample leaves as a beat on the results channel. The
// flag is 1 when the correlation of the newest 60-tap window with the
// topology pattern is strictly greater than detect_threshold.
// Sequencing: an accepted sample sets the start register; its partial sum
// walks through a chain of 60 cells, one cell per cycle, and its flag is then
// registered in the output or holding register, clearing the in-flight mark,
// so no new sample is taken before the previous sum has left the chain.
// The sample line stays frozen while a sum is in flight.
// Registers (APB, byte addresses 0, 4, 8): topology, vppm_mode, detect_threshold.
// They are to be written only while the block is idle; the block does not enforce it.
// Reset: the 119-entry sample history clears to zero, so taps that reach
// past the first samples read zero; registers return to topology 0,
// consecutive taps and a threshold of 40.
// Stall: if the receiver holds ready low, the finished flag waits in the
// output register (and one more in a holding register); samples.ready stays
// low until the pending flag has moved on, so nothing is dropped.
module tdp_preamble_correlator_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tdp_pc_pkg::ADDR_W-1:0]      paddr,
    input  logic [tdp_pc_pkg::DATA_W-1:0]      pwdata,
    output logic [tdp_pc_pkg::DATA_W-1:0]      prdata,
    output logic                               pready,
    tdp_pc_sample_if.sink                      samples,
    tdp_pc_detect_if.source                    results
);
    import tdp_pc_pkg::*;

    // Configuration registers.
    logic [TOPO_W-1:0]        topology_reg;
    logic [TOPO_W-1:0]        topology_next;
    logic                     vppm_reg;
    logic                     vppm_next;
    logic signed [THR_W-1:0]  thr_reg;
    logic signed [THR_W-1:0]  thr_next;
    logic                     cfg_wr;
    logic [REG_IDX_W-1:0]     reg_idx;

    // Sample history: entry 0 is the newest sample.
    logic signed [SAMPLE_W-1:0] hist_reg  [HIST_DEPTH];
    logic signed [SAMPLE_W-1:0] hist_next [HIST_DEPTH];

    // Sequencing and output staging.
    logic     in_beat;
    logic     start_reg;
    logic     start_next;
    logic     flight_reg;
    logic     flight_next;
    logic     pend_reg;
    logic     pend_next;
    logic     pend_det_reg;
    logic     pend_det_next;
    logic     out_valid_reg;
    logic     out_valid_next;
    logic     out_det_reg;
    logic     out_det_next;
    logic     out_free;
    logic     det_now;

    psum_t    chain_in  [PATTERN_CHIPS];
    psum_t    chain_out [PATTERN_CHIPS];
    psum_t    last;

    // APB register port. pready is tied high; writes land on the access phase.
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_comb
    begin
        topology_next = topology_reg;
        vppm_next     = vppm_reg;
        thr_next      = thr_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_TOPOLOGY:  topology_next = pwdata[TOPO_W-1:0];
                REG_VPPM:      vppm_next     = pwdata[0];
                REG_THRESHOLD: thr_next      = signed'(pwdata[THR_W-1:0]);
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_TOPOLOGY:  prdata = DATA_W'(topology_reg);
            REG_VPPM:      prdata = DATA_W'(vppm_reg);
            REG_THRESHOLD: prdata = DATA_W'(thr_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            topology_reg <= '0;
            vppm_reg     <= 1'b0;
            thr_reg      <= THR_RESET;
        end
        else
        begin
            topology_reg <= topology_next;
            vppm_reg     <= vppm_next;
            thr_reg      <= thr_next;
        end
    end

    // Input side: one sample at a time, taken only when nothing is in flight
    // and no finished flag is parked in the holding register.
    assign samples.ready = ~flight_reg & ~pend_reg;
    assign in_beat       = samples.valid & samples.ready;

    always_comb
    begin
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            hist_next[i] = hist_reg[i];
        end
        if (in_beat)
        begin
            hist_next[0] = samples.sample;
            for (int i = 1; i < HIST_DEPTH; i++)
            begin
                hist_next[i] = hist_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
            begin
                hist_reg[i] <= hist_next[i];
            end
        end
    end

    // Cell c meets the sample of age c (or 2c in VPPM mode) and carries
    // chip 59-c of the pattern. The second and fourth quarters are inverted.
    assign chain_in[0].valid = start_reg;
    assign chain_in[0].sum   = '0;

    for (genvar c = 0; c < PATTERN_CHIPS; c++)
    begin : g_cell
        localparam int CHIP = PATTERN_CHIPS - 1 - c;
        localparam int POS  = CHIP % BASE_CHIPS;
        localparam bit INV  = ((CHIP / BASE_CHIPS) % 2) == 1;

        cell_ctl_t ctl;

        assign ctl.vppm = vppm_reg;
        assign ctl.neg  = BASE_NEG[topology_reg][POS] ^ INV;

        if (c > 0)
        begin : g_link
            assign chain_in[c] = chain_out[c-1];
        end

        tdp_pc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .tap_lin  (hist_reg[c]),
            .tap_vppm (hist_reg[2*c]),
            .psum_in  (chain_in[c]),
            .psum_out (chain_out[c])
        );
    end

    assign last    = chain_out[PATTERN_CHIPS-1];
    assign det_now = last.sum > thr_reg;

    // Output side: the output register, backed by one holding register so a
    // flag that finishes while the receiver stalls is never lost.
    assign out_free = ~out_valid_reg | results.ready;

    always_comb
    begin
        start_next     = in_beat;
        flight_next    = flight_reg;
        pend_next      = pend_reg;
        pend_det_next  = pend_det_reg;
        out_valid_next = out_valid_reg;
        out_det_next   = out_det_reg;

        if (in_beat)
        begin
            flight_next = 1'b1;
        end
        else if (last.valid)
        begin
            flight_next = 1'b0;
        end

        if (out_free)
        begin
            if (pend_reg)
            begin
                out_valid_next = 1'b1;
                out_det_next   = pend_det_reg;
                pend_next      = 1'b0;
            end
            else if (last.valid)
            begin
                out_valid_next = 1'b1;
                out_det_next   = det_now;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (last.valid)
        begin
            pend_next     = 1'b1;
            pend_det_next = det_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= 1'b0;
            flight_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg     <= start_next;
            flight_reg    <= flight_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_det_reg <= pend_det_next;
        out_det_reg  <= out_det_next;
    end

    assign results.valid    = out_valid_reg;
    assign results.detected = out_det_reg;

    // Checks on the sequencing.
    logic [PATTERN_CHIPS:0] token_vec;

    always_comb
    begin
        token_vec[0] = start_reg;
        for (int i = 0; i < PATTERN_CHIPS; i++)
        begin
            token_vec[i+1] = chain_out[i].valid;
        end
    end

    a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(token_vec))
        else $error("more than one partial sum in the cell chain");

    a_hold_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> out_valid_reg)
        else $error("holding register full while output register is empty");

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !samples.ready)
        else $error("input accepted again while a sum is in flight");

    a_last_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        last.valid |-> (flight_reg && !in_beat))
        else $error("finished sum without a sample in flight");

endmodule

// File: design/tdp_pc_cell.sv
// One correlator cell: adds or subtracts its signed tap to or from the partial sum and passes it on.
module tdp_pc_cell (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tdp_pc_pkg::cell_ctl_t                ctl,
    input  logic signed [tdp_pc_pkg::SAMPLE_W-1:0] tap_lin,
    input  logic signed [tdp_pc_pkg::SAMPLE_W-1:0] tap_vppm,
    input  tdp_pc_pkg::psum_t                    psum_in,
    output tdp_pc_pkg::psum_t                    psum_out
);
    import tdp_pc_pkg::*;

    logic                       valid_reg;
    logic                       valid_next;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [SAMPLE_W-1:0] tap;
    logic signed [SUM_W-1:0]    term;

    always_comb
    begin
        tap        = ctl.vppm ? tap_vppm : tap_lin;
        term       = SUM_W'(tap);
        sum_next   = ctl.neg ? (psum_in.sum - term) : (psum_in.sum + term);
        valid_next = psum_in.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign psum_out.valid = valid_reg;
    assign psum_out.sum   = sum_reg;
endmodule
